@@ design/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LPOF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lpof assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LPOF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lpof assertion failed");

`endif

@@ design/lpof_pkg.sv @@
// shared types, widths and constants of the line pattern occurrence filter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package lpof_pkg;

	localparam int PATTERN_MAX_DEF      = 8;
	localparam int LINE_NUMBER_BITS_DEF = 32;

	localparam int PATTERN_BYTES_MAX = 8;
	localparam int BYTE_W            = 8;
	localparam int LEN_W             = 4;
	localparam int PATTERN_W         = 64;
	localparam int TARGET_W          = 10;
	localparam int COUNT_W           = 11;
	localparam int SINCE_W           = 4;
	localparam int OUT_W             = 32;
	localparam int CFG_INDEX_W       = 2;
	localparam int CFG_DATA_W        = 64;

	localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'd10;
	localparam logic [BYTE_W-1:0]  ZERO_BYTE    = 8'd0;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'd2047;
	localparam logic [SINCE_W-1:0] SINCE_MAX    = 4'd15;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_PATTERN_BYTES  = 2'd1,
		REG_TARGET_COUNT   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0]     pattern_length;
		logic [PATTERN_W-1:0] pattern_bytes;
		logic [TARGET_W-1:0]  target_count;
	} cfg_t;

	typedef struct packed {
		logic             hit;
		logic [OUT_W-1:0] line_number;
	} res_t;

endpackage

@@ design/line_pattern_occurrence_filter.sv @@
// top level of the line pattern occurrence filter
// depends on lpof_pkg, lpof_cfg_regs, lpof_in_stage, lpof_matcher, lpof_out_reg
`timescale 1ns / 1ps

// Counts leftmost, non-overlapping occurrences of a pattern of up to eight
// bytes in each newline-terminated line of a byte stream, and emits the
// line number of every line whose count equals a nonzero target_count. One
// item is taken per cycle for as long as out_ready stays high: an item is
// latched in the input register, then, once the result register is free,
// the window compare and the counter update run and a selected line number
// enters the result register, which raises out_valid for the item closing
// the line. The result register is the only stall point; while a result
// waits, the input register still takes one more item.
// end_of_text closes a non-empty final line and restarts numbering at 1.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while no item is in flight (not enforced here).
module line_pattern_occurrence_filter #(
	parameter int PATTERN_MAX      = lpof_pkg::PATTERN_MAX_DEF,
	parameter int LINE_NUMBER_BITS = lpof_pkg::LINE_NUMBER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lpof_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lpof_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lpof_pkg::BYTE_W-1:0]      text_byte,
	input  logic                             end_of_text,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lpof_pkg::OUT_W-1:0]       line_number
);

	lpof_pkg::cfg_t  cfg;
	lpof_pkg::item_t item_s1;
	lpof_pkg::res_t  res;
	logic            fire;
	logic            out_free;

	lpof_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpof_in_stage u_in_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_free    (out_free),
		.fire        (fire),
		.item_s1     (item_s1)
	);

	lpof_matcher #(
		.PATTERN_MAX      (PATTERN_MAX),
		.LINE_NUMBER_BITS (LINE_NUMBER_BITS)
	) u_matcher (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	lpof_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.res         (res),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.line_number (line_number),
		.out_free    (out_free)
	);

endmodule

@@ design/lpof_cfg_regs.sv @@
// configuration registers: pattern length, pattern bytes, target count
// depends on lpof_pkg
`timescale 1ns / 1ps

module lpof_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [lpof_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lpof_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lpof_pkg::cfg_t                     cfg
);

	lpof_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_length <= '0;
			cfg_q.pattern_bytes  <= '0;
			cfg_q.target_count   <= lpof_pkg::TARGET_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				lpof_pkg::REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[lpof_pkg::LEN_W-1:0];
				end
				lpof_pkg::REG_PATTERN_BYTES: begin
					cfg_q.pattern_bytes <= cfg_data[lpof_pkg::PATTERN_W-1:0];
				end
				lpof_pkg::REG_TARGET_COUNT: begin
					cfg_q.target_count <= cfg_data[lpof_pkg::TARGET_W-1:0];
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/lpof_in_stage.sv @@
// input register stage: holds one item until the matcher can take it
// depends on lpof_pkg
`timescale 1ns / 1ps

module lpof_in_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lpof_pkg::BYTE_W-1:0] text_byte,
	input  logic                        end_of_text,
	input  logic                        out_free,
	output logic                        fire,
	output lpof_pkg::item_t             item_s1
);

	logic valid_s1;

	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.text_byte   <= text_byte;
			item_s1.end_of_text <= end_of_text;
		end
	end

endmodule

@@ design/lpof_matcher.sv @@
// line state, masked window compare, match counter and line close decision
// depends on lpof_pkg
`timescale 1ns / 1ps

module lpof_matcher #(
	parameter int PATTERN_MAX      = lpof_pkg::PATTERN_MAX_DEF,
	parameter int LINE_NUMBER_BITS = lpof_pkg::LINE_NUMBER_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  lpof_pkg::item_t item_s1,
	input  lpof_pkg::cfg_t  cfg,
	output lpof_pkg::res_t  res
);

	localparam int WIN_BYTES = (PATTERN_MAX < lpof_pkg::PATTERN_BYTES_MAX) ?
		PATTERN_MAX : lpof_pkg::PATTERN_BYTES_MAX;
	localparam int WIN_BITS  = WIN_BYTES * lpof_pkg::BYTE_W;
	localparam logic [lpof_pkg::LEN_W-1:0] WIN_LEN = lpof_pkg::LEN_W'(WIN_BYTES);
	localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX = '1;
	localparam logic [LINE_NUMBER_BITS-1:0] LINE_ONE = LINE_NUMBER_BITS'(1);

	logic [WIN_BITS-1:0]                  recent_q, recent_d, recent_shift;
	logic [lpof_pkg::SINCE_W-1:0]         since_q, since_d, since_inc;
	logic [lpof_pkg::COUNT_W-1:0]         count_q, count_d, count_inc;
	logic [LINE_NUMBER_BITS-1:0]          line_q, line_d, line_inc;
	logic                                 zero_q, zero_d, zero_next;
	logic                                 has_q, has_d;
	logic [lpof_pkg::LEN_W-1:0]           len_used;
	logic [WIN_BYTES-1:0]                 byte_ok;
	logic                                 match;
	logic                                 close_sel;
	logic                                 is_newline;

	assign is_newline   = item_s1.text_byte == lpof_pkg::NEWLINE_BYTE;
	assign recent_shift = WIN_BITS'({recent_q, item_s1.text_byte});
	assign since_inc    = (since_q == lpof_pkg::SINCE_MAX) ? since_q :
		since_q + lpof_pkg::SINCE_W'(1);
	assign count_inc    = (count_q == lpof_pkg::COUNT_MAX) ? count_q :
		count_q + lpof_pkg::COUNT_W'(1);
	assign line_inc     = (line_q == LINE_MAX) ? line_q : line_q + LINE_ONE;
	assign zero_next    = zero_q || (item_s1.text_byte == lpof_pkg::ZERO_BYTE);
	assign len_used     = (cfg.pattern_length > WIN_LEN) ? WIN_LEN : cfg.pattern_length;
	assign close_sel    = (cfg.target_count != '0) &&
		(count_q == lpof_pkg::COUNT_W'(cfg.target_count));

	// bytes at or beyond the pattern length are masked out
	always_comb begin
		for (int i = 0; i < WIN_BYTES; i++) begin
			byte_ok[i] = (lpof_pkg::LEN_W'(i) >= len_used) ||
				(recent_shift[i*lpof_pkg::BYTE_W +: lpof_pkg::BYTE_W] ==
				 cfg.pattern_bytes[i*lpof_pkg::BYTE_W +: lpof_pkg::BYTE_W]);
		end
	end

	assign match = !zero_next && (len_used != '0) &&
		(since_inc >= len_used) && (&byte_ok);

	always_comb begin
		recent_d = recent_q;
		since_d  = since_q;
		count_d  = count_q;
		line_d   = line_q;
		zero_d   = zero_q;
		has_d    = has_q;
		res.hit  = 1'b0;
		res.line_number = lpof_pkg::OUT_W'(line_q);
		if (fire) begin
			priority if (item_s1.end_of_text) begin
				res.hit  = has_q && close_sel;
				recent_d = '0;
				since_d  = '0;
				count_d  = '0;
				zero_d   = 1'b0;
				has_d    = 1'b0;
				line_d   = LINE_ONE;
			end else if (is_newline) begin
				// empty lines close too and advance the number
				res.hit  = close_sel;
				recent_d = '0;
				since_d  = '0;
				count_d  = '0;
				zero_d   = 1'b0;
				has_d    = 1'b0;
				line_d   = line_inc;
			end else begin
				recent_d = recent_shift;
				zero_d   = zero_next;
				has_d    = 1'b1;
				if (match) begin
					count_d = count_inc;
					since_d = '0;
				end else begin
					since_d = since_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			since_q  <= '0;
			count_q  <= '0;
			line_q   <= LINE_ONE;
			zero_q   <= 1'b0;
			has_q    <= 1'b0;
		end else begin
			recent_q <= recent_d;
			since_q  <= since_d;
			count_q  <= count_d;
			line_q   <= line_d;
			zero_q   <= zero_d;
			has_q    <= has_d;
		end
	end

endmodule

@@ design/lpof_out_reg.sv @@
// result register: holds one line number until the consumer takes it
// depends on lpof_pkg
`timescale 1ns / 1ps

module lpof_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  lpof_pkg::res_t             res,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [lpof_pkg::OUT_W-1:0] line_number,
	output logic                       out_free
);

	logic                       out_valid_q;
	logic [lpof_pkg::OUT_W-1:0] line_number_q;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res.hit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.hit) begin
			line_number_q <= res.line_number;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_number = line_number_q;

endmodule

@@ design/lpof_checker.sv @@
// port-level checker for the line pattern occurrence filter, bound to the top
// depends on lpof_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpof_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [lpof_pkg::OUT_W-1:0] line_number
);

	`LPOF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`LPOF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(line_number))
	`LPOF_ASSERT_IMPLY(a_line_nonzero, clk, arst_n, out_valid, line_number != '0)
	// a fresh result comes from an item taken in through the input register
	`LPOF_ASSERT_IMPLY(a_rise_cause, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))
	// with no result waiting the input side never stalls
	`LPOF_ASSERT_IMPLY(a_ready_free, clk, arst_n, !out_valid, in_ready)

endmodule

bind line_pattern_occurrence_filter lpof_checker u_lpof_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.line_number (line_number)
);
